// ----- hw/rtl/assert_macros.svh -----
// shared assertion macros, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SFE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define SFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/sfe_pkg.sv -----
`default_nettype none

package sfe_pkg;

  localparam logic [30:0] K_RESET = 31'd65536;
  localparam logic [49:0] POS_CAP = 50'h0_7FFF_FFFF;
  localparam logic [49:0] NEG_CAP = 50'h0_8000_0000;
  localparam logic [30:0] U_MAX   = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [30:0]        rest_length;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
    logic               fixed_a;
    logic               fixed_b;
  } item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] accel_a_x;
    logic signed [31:0] accel_a_y;
    logic signed [31:0] accel_a_z;
    logic signed [31:0] accel_b_x;
    logic signed [31:0] accel_b_y;
    logic signed [31:0] accel_b_z;
    logic               degenerate;
  } res_t;

  // per-spring data carried down the pipe
  typedef struct packed {
    logic [2:0]        sneg;
    logic [2:0][32:0]  smag;
    logic [30:0]       rest;
    logic [30:0]       inv_a;
    logic [30:0]       inv_b;
    logic              fixed_a;
    logic              fixed_b;
  } carry_t;

  // cap a magnitude by the sign it will carry
  function automatic logic [31:0] sat_mag(input logic [49:0] mag, input logic neg);
    logic [49:0] cap;
    cap = neg ? NEG_CAP : POS_CAP;
    return (mag > cap) ? cap[31:0] : mag[31:0];
  endfunction

  function automatic logic [31:0] to_field(input logic [31:0] m, input logic neg);
    return neg ? (32'd0 - m) : m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spring_force_eval_unit.sv -----
// channel  | dir | handshake          | beat
// item     | in  | item_valid/stall   | sfe_pkg::item_t, one spring
// res      | out | res_valid/stall    | sfe_pkg::res_t, force and accel deltas
// cfg      | in  | cfg_valid/ready    | spring constant k, 31 bit
//
// one beat per cycle in unless item_stall is high, one result beat per item out:
// separation and sum of squares, then the root (one bit a stage), then the
// extension, the division (one quotient bit a stage), and last the multiply,
// saturate and output register
// rst is synchronous; it clears every stage valid and loads k with 1.0
// a stall on res freezes the whole pipe; item_stall follows it directly
`default_nettype none
`include "assert_macros.svh"

module spring_force_eval_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  sfe_pkg::item_t item,
  output logic          res_valid,
  input  logic          res_stall,
  output sfe_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data
);

  // spring constant register, always writable
  logic [30:0] k;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= sfe_pkg::K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k <= cfg_data;
    end
  end

  // whole pipe moves unless the output beat is held
  logic en;
  assign en         = !(res_valid && res_stall);
  assign item_stall = !en;

  // ---------------- stage 0: separation magnitudes
  logic [31:0]      pa [3];
  logic [31:0]      pb [3];
  sfe_pkg::carry_t  c0_next;
  always_comb begin
    logic [32:0] sd;
    pa[0] = item.a_x; pa[1] = item.a_y; pa[2] = item.a_z;
    pb[0] = item.b_x; pb[1] = item.b_y; pb[2] = item.b_z;
    c0_next = '0;
    for (int c = 0; c < 3; c++) begin
      sd = {pb[c][31], pb[c]} - {pa[c][31], pa[c]};
      c0_next.sneg[c] = sd[32];
      c0_next.smag[c] = sd[32] ? (33'd0 - sd) : sd;
    end
    c0_next.rest    = item.rest_length;
    c0_next.inv_a   = item.inv_mass_a;
    c0_next.inv_b   = item.inv_mass_b;
    c0_next.fixed_a = item.fixed_a;
    c0_next.fixed_b = item.fixed_b;
  end

  logic            s0_v;
  sfe_pkg::carry_t s0_c;
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= item_valid;
  end
  always_ff @(posedge clk) begin
    if (en) s0_c <= c0_next;
  end

  // ---------------- stage 1: squares
  logic [65:0]       sq_full [3];
  logic [2:0][64:0]  s1_sq;
  logic              s1_v;
  sfe_pkg::carry_t   s1_c;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_full[c] = s0_c.smag[c] * s0_c.smag[c];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s0_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) s1_sq[c] <= sq_full[c][64:0];
      s1_c <= s0_c;
    end
  end

  // ---------------- stage 2: sum of squares, coinciding nodes
  logic [65:0]     sum_next;
  logic [65:0]     s2_sum;
  logic            s2_deg;
  logic            s2_v;
  sfe_pkg::carry_t s2_c;
  assign sum_next = {1'b0, s1_sq[0]} + {1'b0, s1_sq[1]} + {1'b0, s1_sq[2]};
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum <= sum_next;
      s2_deg <= (sum_next == 66'd0);
      s2_c   <= s1_c;
    end
  end

  // ---------------- root: one result bit a stage, two radicand bits in
  logic [65:0]     rt_sum  [1:33];
  logic [35:0]     rt_rem  [1:33];
  logic [32:0]     rt_root [1:33];
  logic            rt_deg  [1:33];
  logic            rt_v    [1:33];
  sfe_pkg::carry_t rt_c    [1:33];

  for (genvar g = 0; g < 33; g++) begin : g_root
    localparam int I = 32 - g;
    logic [65:0]     src_sum;
    logic [35:0]     src_rem;
    logic [32:0]     src_root;
    logic            src_deg;
    logic            src_v;
    sfe_pkg::carry_t src_c;
    logic [35:0]     rsh;
    logic [35:0]     trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign src_sum  = s2_sum;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_deg  = s2_deg;
      assign src_v    = s2_v;
      assign src_c    = s2_c;
    end else begin : g_rest
      assign src_sum  = rt_sum[g];
      assign src_rem  = rt_rem[g];
      assign src_root = rt_root[g];
      assign src_deg  = rt_deg[g];
      assign src_v    = rt_v[g];
      assign src_c    = rt_c[g];
    end

    assign rsh   = {src_rem[33:0], src_sum[2*I+1:2*I]};
    assign trial = {1'b0, src_root, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) rt_v[g+1] <= 1'b0;
      else if (en) rt_v[g+1] <= src_v;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_sum[g+1]  <= src_sum;
        rt_rem[g+1]  <= ge ? (rsh - trial) : rsh;
        rt_root[g+1] <= {src_root[31:0], ge};
        rt_deg[g+1]  <= src_deg;
        rt_c[g+1]    <= src_c;
      end
    end
  end

  // ---------------- extension E = D - rest
  logic [34:0]     ediff;
  logic [34:0]     emag_full;
  logic [32:0]     e_dist;
  logic [33:0]     e_emag;
  logic            e_eneg;
  logic            e_deg;
  logic            e_v;
  sfe_pkg::carry_t e_c;
  assign ediff     = {2'b00, rt_root[33]} - {4'b0000, rt_c[33].rest};
  assign emag_full = ediff[34] ? (35'd0 - ediff) : ediff;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= rt_v[33];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_dist <= rt_root[33];
      e_emag <= emag_full[33:0];
      e_eneg <= ediff[34];
      e_deg  <= rt_deg[33];
      e_c    <= rt_c[33];
    end
  end

  // ---------------- unit vector: (|s| << 30) / D, restoring, one bit a stage
  // |s| <= D, so the quotient stays within 31 bits and |s| >> 1 starts below D
  logic [2:0][33:0] d_rem  [1:31];
  logic [2:0][30:0] d_q    [1:31];
  logic [32:0]      d_dist [1:31];
  logic [33:0]      d_emag [1:31];
  logic             d_eneg [1:31];
  logic             d_deg  [1:31];
  logic             d_v    [1:31];
  sfe_pkg::carry_t  d_c    [1:31];

  for (genvar g = 0; g < 31; g++) begin : g_div
    logic [2:0][33:0] src_rem;
    logic [2:0][30:0] src_q;
    logic [32:0]      src_dist;
    logic [33:0]      src_emag;
    logic             src_eneg;
    logic             src_deg;
    logic             src_v;
    sfe_pkg::carry_t  src_c;
    logic [2:0][33:0] rem_next;
    logic [2:0][30:0] q_next;

    if (g == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          src_rem[c] = {2'b00, e_c.smag[c][32:1]};
        end
      end
      assign src_q    = '0;
      assign src_dist = e_dist;
      assign src_emag = e_emag;
      assign src_eneg = e_eneg;
      assign src_deg  = e_deg;
      assign src_v    = e_v;
      assign src_c    = e_c;
    end else begin : g_rest
      assign src_rem  = d_rem[g];
      assign src_q    = d_q[g];
      assign src_dist = d_dist[g];
      assign src_emag = d_emag[g];
      assign src_eneg = d_eneg[g];
      assign src_deg  = d_deg[g];
      assign src_v    = d_v[g];
      assign src_c    = d_c[g];
    end

    always_comb begin
      logic [34:0] rsh;
      logic        bit_in;
      logic        ge;
      for (int c = 0; c < 3; c++) begin
        bit_in      = (g == 0) ? src_c.smag[c][0] : 1'b0;
        rsh         = {src_rem[c], bit_in};
        ge          = (rsh >= {2'b00, src_dist});
        rem_next[c] = ge ? (rsh[33:0] - {1'b0, src_dist}) : rsh[33:0];
        q_next[c]   = {src_q[c][29:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) d_v[g+1] <= 1'b0;
      else if (en) d_v[g+1] <= src_v;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[g+1]  <= rem_next;
        d_q[g+1]    <= q_next;
        d_dist[g+1] <= src_dist;
        d_emag[g+1] <= src_emag;
        d_eneg[g+1] <= src_eneg;
        d_deg[g+1]  <= src_deg;
        d_c[g+1]    <= src_c;
      end
    end
  end

  // ---------------- m1: u * k
  logic [2:0][61:0] m1_pk;
  logic [33:0]      m1_emag;
  logic             m1_eneg;
  logic             m1_deg;
  logic             m1_v;
  sfe_pkg::carry_t  m1_c;
  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (en) m1_v <= d_v[31];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) m1_pk[c] <= d_q[31][c] * k;
      m1_emag <= d_emag[31];
      m1_eneg <= d_eneg[31];
      m1_deg  <= d_deg[31];
      m1_c    <= d_c[31];
    end
  end

  // ---------------- m2: (u*k) * |E| as four partial products
  logic [2:0][47:0] m2_ll;
  logic [2:0][47:0] m2_lh;
  logic [2:0][47:0] m2_hl;
  logic [2:0][47:0] m2_hh;
  logic             m2_eneg;
  logic             m2_deg;
  logic             m2_v;
  sfe_pkg::carry_t  m2_c;
  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (en) m2_v <= m1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        m2_ll[c] <= m1_pk[c][30:0]  * m1_emag[16:0];
        m2_lh[c] <= m1_pk[c][30:0]  * m1_emag[33:17];
        m2_hl[c] <= m1_pk[c][61:31] * m1_emag[16:0];
        m2_hh[c] <= m1_pk[c][61:31] * m1_emag[33:17];
      end
      m2_eneg <= m1_eneg;
      m2_deg  <= m1_deg;
      m2_c    <= m1_c;
    end
  end

  // ---------------- m3: sum partials, drop 46 fraction bits, saturate force
  // force points against the separation when stretched: negative when s and E agree
  logic [2:0][31:0] fcap_next;
  logic [2:0]       fneg_next;
  always_comb begin
    logic [95:0] full;
    for (int c = 0; c < 3; c++) begin
      full = {48'd0, m2_ll[c]} + ({48'd0, m2_lh[c]} << 17)
           + ({48'd0, m2_hl[c]} << 31) + ({48'd0, m2_hh[c]} << 48);
      fneg_next[c] = (m2_c.sneg[c] == m2_eneg);
      fcap_next[c] = sfe_pkg::sat_mag(full[95:46], fneg_next[c]);
    end
  end

  logic [2:0][31:0] m3_fcap;
  logic [2:0]       m3_fneg;
  logic             m3_deg;
  logic             m3_v;
  sfe_pkg::carry_t  m3_c;
  always_ff @(posedge clk) begin
    if (rst) m3_v <= 1'b0;
    else if (en) m3_v <= m2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m3_fcap <= fcap_next;
      m3_fneg <= fneg_next;
      m3_deg  <= m2_deg;
      m3_c    <= m2_c;
    end
  end

  // ---------------- m4: saturated force times inverse masses
  logic [2:0][62:0] m4_pa;
  logic [2:0][62:0] m4_pb;
  logic [2:0][31:0] m4_fcap;
  logic [2:0]       m4_fneg;
  logic             m4_deg;
  logic             m4_v;
  sfe_pkg::carry_t  m4_c;
  always_ff @(posedge clk) begin
    if (rst) m4_v <= 1'b0;
    else if (en) m4_v <= m3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        m4_pa[c] <= m3_fcap[c] * m3_c.inv_a;
        m4_pb[c] <= m3_fcap[c] * m3_c.inv_b;
      end
      m4_fcap <= m3_fcap;
      m4_fneg <= m3_fneg;
      m4_deg  <= m3_deg;
      m4_c    <= m3_c;
    end
  end

  // ---------------- output register: shift, saturate, pinned and coincident nodes
  sfe_pkg::res_t    res_next;
  logic [2:0][31:0] f_fld;
  logic [2:0][31:0] a_fld;
  logic [2:0][31:0] b_fld;
  always_comb begin
    logic [31:0] am;
    logic [31:0] bm;
    for (int c = 0; c < 3; c++) begin
      am = sfe_pkg::sat_mag({3'b000, m4_pa[c][62:16]}, !m4_fneg[c]);
      bm = sfe_pkg::sat_mag({3'b000, m4_pb[c][62:16]}, m4_fneg[c]);
      f_fld[c] = m4_deg ? 32'd0 : sfe_pkg::to_field(m4_fcap[c], m4_fneg[c]);
      a_fld[c] = (m4_deg || m4_c.fixed_a) ? 32'd0 : sfe_pkg::to_field(am, !m4_fneg[c]);
      b_fld[c] = (m4_deg || m4_c.fixed_b) ? 32'd0 : sfe_pkg::to_field(bm, m4_fneg[c]);
    end
    res_next.force_x    = f_fld[0];
    res_next.force_y    = f_fld[1];
    res_next.force_z    = f_fld[2];
    res_next.accel_a_x  = a_fld[0];
    res_next.accel_a_y  = a_fld[1];
    res_next.accel_a_z  = a_fld[2];
    res_next.accel_b_x  = b_fld[0];
    res_next.accel_b_y  = b_fld[1];
    res_next.accel_b_z  = b_fld[2];
    res_next.degenerate = m4_deg;
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (en) res_valid <= m4_v;
  end
  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

  // ---------------- checks
  logic        res_zero;
  logic [66:0] root_w;
  logic [66:0] root_lo_sq;
  logic [66:0] root_hi_sq;
  logic [66:0] sum_w;
  assign res_zero = (res.force_x == 32'sd0) && (res.force_y == 32'sd0)
                 && (res.force_z == 32'sd0) && (res.accel_a_x == 32'sd0)
                 && (res.accel_a_y == 32'sd0) && (res.accel_a_z == 32'sd0)
                 && (res.accel_b_x == 32'sd0) && (res.accel_b_y == 32'sd0)
                 && (res.accel_b_z == 32'sd0);
  assign root_w     = {34'd0, rt_root[33]};
  assign root_lo_sq = root_w * root_w;
  assign root_hi_sq = (root_w + 67'd1) * (root_w + 67'd1);
  assign sum_w      = {1'b0, rt_sum[33]};

  `SFE_ASSERT_IMPLIES(a_degenerate_zero, clk, rst, res_valid && res.degenerate, res_zero, "coincident nodes gave a nonzero result")
  `SFE_ASSERT_IMPLIES(a_root_floor, clk, rst, rt_v[33], root_lo_sq <= sum_w && root_hi_sq > sum_w, "root is not the floor square root")
  `SFE_ASSERT_IMPLIES(a_unit_bound, clk, rst, d_v[31] && !d_deg[31], d_q[31][0] <= sfe_pkg::U_MAX && d_q[31][1] <= sfe_pkg::U_MAX && d_q[31][2] <= sfe_pkg::U_MAX, "unit component above one")
  `SFE_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, $stable(e_v) && $stable(m4_v) && $stable(m4_fcap), "pipe moved during a stall")

endmodule

`default_nettype wire
